[rtl/core/tpms_pkg.sv]
// ----------------------------------------------------------------------------
// tpms_pkg
// Shared types and constants of the two-pattern span finder: default sizes,
// register indexes and the structs passed between the cells and the tracker.
// ----------------------------------------------------------------------------
package tpms_pkg;

  // default sizes
  localparam int PATTERN_MAX_DEF = 8;
  localparam int TEXT_MAX_DEF    = 512;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_REG_W  = 4;
  localparam int SPAN_W     = 10;
  localparam int SPAN_MAX   = 511;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PATTERN  = 2'd0,
    CFG_FIRST_LENGTH   = 2'd1,
    CFG_SECOND_PATTERN = 2'd2,
    CFG_SECOND_LENGTH  = 2'd3
  } cfg_reg_t;

  // per-cycle control of the cell row
  typedef struct packed {
    logic shift;
    logic flush;
  } cell_ctl_t;

  // compare result of one cell against both patterns
  typedef struct packed {
    logic hit_first;
    logic hit_second;
  } cell_hit_t;

  // flags of the word held between the cell row and the tracker
  typedef struct packed {
    logic vld;
    logic last;
    logic srch;
  } stage_t;

endpackage

[rtl/core/tpms_cell.sv]
// ----------------------------------------------------------------------------
// tpms_cell
// One cell of the text window: holds one recent byte with its valid bit,
// hands it to the next cell on each shift and compares it with the pattern
// byte that lines up with its distance from the newest byte.
// ----------------------------------------------------------------------------
module tpms_cell #(
  parameter int PATTERN_MAX = 8,
  parameter int CELL_IDX    = 0,
  parameter int LEN_W       = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tpms_pkg::cell_ctl_t                    ctl,
  input  logic [tpms_pkg::BYTE_W-1:0]            byte_in,
  input  logic                                   vld_in,
  output logic [tpms_pkg::BYTE_W-1:0]            byte_out,
  output logic                                   vld_out,
  input  logic [PATTERN_MAX*tpms_pkg::BYTE_W-1:0] first_pat,
  input  logic [LEN_W-1:0]                       first_len,
  input  logic [PATTERN_MAX*tpms_pkg::BYTE_W-1:0] second_pat,
  input  logic [LEN_W-1:0]                       second_len,
  output tpms_pkg::cell_hit_t                    hit
);
  import tpms_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic              vld_r;
  logic              vld_nxt;
  logic              vld_feed;
  logic [BYTE_W-1:0] first_sel;
  logic [BYTE_W-1:0] second_sel;

  // a shifted-in byte of the previous text loses its valid bit on flush
  assign vld_feed = (CELL_IDX == 0) ? vld_in : (vld_in & ~ctl.flush);

  // valid bit
  always_comb begin
    if (ctl.shift) begin
      vld_nxt = vld_feed;
    end else if (ctl.flush) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // byte storage
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign vld_out  = vld_r;

  // pick pattern byte len-1-k for this cell
  always_comb begin
    first_sel  = '0;
    second_sel = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if ((j + CELL_IDX + 1) == int'(first_len)) begin
        first_sel = first_pat[j*BYTE_W +: BYTE_W];
      end
      if ((j + CELL_IDX + 1) == int'(second_len)) begin
        second_sel = second_pat[j*BYTE_W +: BYTE_W];
      end
    end
  end

  // cells beyond the pattern length never block a match
  assign hit.hit_first  = (int'(first_len) <= CELL_IDX) ||
                          (vld_r && (byte_r == first_sel));
  assign hit.hit_second = (int'(second_len) <= CELL_IDX) ||
                          (vld_r && (byte_r == second_sel));

endmodule

[rtl/core/tpms_tracker.sv]
// ----------------------------------------------------------------------------
// tpms_tracker
// Match bookkeeping: records the end of the first match of pattern one and
// the start of the latest match of pattern two after it, and on the final
// word of a text registers the saturated span, or -1 for a missing match.
// ----------------------------------------------------------------------------
module tpms_tracker #(
  parameter int POS_W = 10,
  parameter int LEN_W = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tpms_pkg::stage_t                   stg,
  input  logic [POS_W-1:0]                   stg_idx,
  input  logic                               hit_first,
  input  logic                               hit_second,
  input  logic [LEN_W-1:0]                   second_len,
  output logic                               stall,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tpms_pkg::SPAN_W-1:0] out_span
);
  import tpms_pkg::*;

  localparam int EXT_W = (POS_W > SPAN_W) ? POS_W : SPAN_W;

  logic              first_found_r, first_found_nxt;
  logic [POS_W-1:0]  first_end_r, first_end_nxt;
  logic              second_found_r, second_found_nxt;
  logic [POS_W-1:0]  second_start_r, second_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SPAN_W-1:0] out_span_r, span_val;
  logic              adv;
  logic              h1, h2;
  logic              sec_ok;
  logic [POS_W:0]    start_w;
  logic [EXT_W-1:0]  diff;

  // the final word waits while the previous result is unclaimed
  assign stall = stg.vld && stg.last && out_valid_r && !out_ready;
  assign adv   = stg.vld && !stall;
  assign h1    = hit_first && stg.srch;
  assign h2    = hit_second && stg.srch;

  // match state update for the word in the stage
  always_comb begin
    first_found_nxt  = first_found_r | h1;
    first_end_nxt    = first_found_r ? first_end_r : stg_idx;
    start_w          = (POS_W+1)'(stg_idx) + (POS_W+1)'(1) - (POS_W+1)'(second_len);
    sec_ok           = first_found_nxt && h2 && (start_w > (POS_W+1)'(first_end_nxt));
    second_found_nxt = second_found_r | sec_ok;
    second_start_nxt = sec_ok ? POS_W'(start_w) : second_start_r;
  end

  // span between the matches, saturated, or -1 if a match is missing
  always_comb begin
    diff = EXT_W'(second_start_nxt) - EXT_W'(first_end_nxt) - EXT_W'(1);
    if (first_found_nxt && second_found_nxt) begin
      if (diff > EXT_W'(SPAN_MAX)) begin
        span_val = SPAN_W'(SPAN_MAX);
      end else begin
        span_val = SPAN_W'(diff);
      end
    end else begin
      span_val = '1;
    end
  end

  // match registers, cleared at end of text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_found_r  <= 1'b0;
      first_end_r    <= '0;
      second_found_r <= 1'b0;
      second_start_r <= '0;
    end else if (adv) begin
      if (stg.last) begin
        first_found_r  <= 1'b0;
        first_end_r    <= '0;
        second_found_r <= 1'b0;
        second_start_r <= '0;
      end else begin
        first_found_r  <= first_found_nxt;
        first_end_r    <= first_end_nxt;
        second_found_r <= second_found_nxt;
        second_start_r <= second_start_nxt;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (adv && stg.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stg.last) begin
      out_span_r <= span_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_span  = signed'(out_span_r);

endmodule

[rtl/core/two_pattern_max_span_finder.sv]
// ----------------------------------------------------------------------------
// two_pattern_max_span_finder
// Streams a text one byte per word and reports the gap between the first
// match of pattern one and the last later match of pattern two.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while in_ready is high. A row of
// PATTERN_MAX cells holds the newest bytes, each cell comparing its byte
// against both patterns; the match flags of a byte are evaluated in the
// cycle after it is taken and registered into the tracker at the end of
// that cycle unless stalled; a final byte then loads its text's span word.
// Input is stalled only when a final byte has reached the tracker while the
// previous span word is still unclaimed. Bytes past TEXT_MAX are taken but
// not searched; out_span is -1 when a match is missing and saturates at 511.
// Configuration is written at any cycle with cfg_ready held high, lengths 0
// and above PATTERN_MAX act as 1 and PATTERN_MAX.
// ----------------------------------------------------------------------------
module two_pattern_max_span_finder #(
  parameter int PATTERN_MAX = tpms_pkg::PATTERN_MAX_DEF,
  parameter int TEXT_MAX    = tpms_pkg::TEXT_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [tpms_pkg::BYTE_W-1:0]            in_text_byte,
  input  logic                                   in_final_byte,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tpms_pkg::SPAN_W-1:0]     out_span,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tpms_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tpms_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import tpms_pkg::*;

  localparam int POS_W = $clog2(TEXT_MAX + 1);
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int PAT_W = PATTERN_MAX * BYTE_W;

  logic [CFG_DATA_W-1:0] first_pat_r, second_pat_r;
  logic [LEN_REG_W-1:0]  first_len_r, second_len_r;
  logic [LEN_W-1:0]      first_len, second_len;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  srch;
  logic                  in_acc;
  stage_t                stg_r;
  logic [POS_W-1:0]      stg_idx_r;
  cell_ctl_t             ctl;
  logic                  stall;
  logic [BYTE_W-1:0]     cell_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_vld;
  cell_hit_t             cell_hit [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit_first_v, hit_second_v;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pat_r  <= '0;
      first_len_r  <= LEN_REG_W'(1);
      second_pat_r <= '0;
      second_len_r <= LEN_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FIRST_PATTERN:  first_pat_r  <= cfg_data;
        CFG_FIRST_LENGTH:   first_len_r  <= cfg_data[LEN_REG_W-1:0];
        CFG_SECOND_PATTERN: second_pat_r <= cfg_data;
        CFG_SECOND_LENGTH:  second_len_r <= cfg_data[LEN_REG_W-1:0];
      endcase
    end
  end

  // effective pattern lengths
  always_comb begin
    if (first_len_r == '0) begin
      first_len = LEN_W'(1);
    end else if (first_len_r > LEN_REG_W'(PATTERN_MAX)) begin
      first_len = LEN_W'(PATTERN_MAX);
    end else begin
      first_len = LEN_W'(first_len_r);
    end
    if (second_len_r == '0) begin
      second_len = LEN_W'(1);
    end else if (second_len_r > LEN_REG_W'(PATTERN_MAX)) begin
      second_len = LEN_W'(PATTERN_MAX);
    end else begin
      second_len = LEN_W'(second_len_r);
    end
  end

  // input handshake
  assign in_ready = !stall;
  assign in_acc   = in_valid && in_ready;
  assign srch     = pos_r < POS_W'(TEXT_MAX);

  // text position
  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      if (in_final_byte) begin
        pos_nxt = '0;
      end else if (srch) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // stage between cell row and tracker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else if (in_acc) begin
      stg_r.vld  <= 1'b1;
      stg_r.last <= in_final_byte;
      stg_r.srch <= srch;
    end else if (!stall) begin
      stg_r.vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_idx_r <= pos_r;
    end
  end

  // cell row control
  assign ctl.shift = in_acc && srch;
  assign ctl.flush = stg_r.vld && stg_r.last && !stall;

  // row of cells, newest byte in cell 0
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    logic              vld_in;

    if (k == 0) begin : g_head
      assign byte_in = in_text_byte;
      assign vld_in  = 1'b1;
    end else begin : g_body
      assign byte_in = cell_byte[k-1];
      assign vld_in  = cell_vld[k-1];
    end

    tpms_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .CELL_IDX    (k),
      .LEN_W       (LEN_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .byte_in    (byte_in),
      .vld_in     (vld_in),
      .byte_out   (cell_byte[k]),
      .vld_out    (cell_vld[k]),
      .first_pat  (first_pat_r[PAT_W-1:0]),
      .first_len  (first_len),
      .second_pat (second_pat_r[PAT_W-1:0]),
      .second_len (second_len),
      .hit        (cell_hit[k])
    );

    assign hit_first_v[k]  = cell_hit[k].hit_first;
    assign hit_second_v[k] = cell_hit[k].hit_second;
  end

  // match bookkeeping and output word
  tpms_tracker #(
    .POS_W (POS_W),
    .LEN_W (LEN_W)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg        (stg_r),
    .stg_idx    (stg_idx_r),
    .hit_first  (&hit_first_v),
    .hit_second (&hit_second_v),
    .second_len (second_len),
    .stall      (stall),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_span   (out_span)
  );

  // a final word reaches the stage in the cycle after it is taken
  a_final_staged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_final_byte) |=> (stg_r.vld && stg_r.last))
    else $error("final word not staged");

  // a new span word only follows a final word in the stage
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stg_r.vld && stg_r.last))
    else $error("span word without final word");

  // negative span words are only the no-match code
  a_span_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span[SPAN_W-1]) |-> (out_span == '1))
    else $error("bad negative span");

  // valid bits of the cell row form a prefix
  a_cell_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("cell valid bits not contiguous");

endmodule
